// ----- hdl/prl_pkg.sv -----
// Shared types and constants of the per-source packet rate limiter.
package prl_pkg;

  localparam int unsigned ADDR_W = 32;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned CNT_W  = 32;
  localparam int unsigned CFG_W  = 31;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_EXPIRY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = 2'd1;

  localparam logic [CFG_W-1:0] EXPIRY_RESET = 31'd600;
  localparam logic [CFG_W-1:0] LIMIT_RESET  = 31'd1000;

  localparam logic [1:0] ST_NEW     = 2'd0;
  localparam logic [1:0] ST_UPDATED = 2'd1;
  localparam logic [1:0] ST_RENEWED = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [TIME_W-1:0] now;
  } req_t;

  typedef struct packed {
    logic [CFG_W-1:0] expiry;
    logic [CFG_W-1:0] limit;
  } cfg_t;

  typedef struct packed {
    logic [CNT_W-1:0]  count;
    logic [TIME_W-1:0] first_seen;
    logic [TIME_W-1:0] age;
  } rec_t;

endpackage

// ----- hdl/prl_front.sv -----
// Front end: accepts requests into a two-deep queue for the lookup engine.
module prl_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  prl_pkg::req_t in_req,
  output logic          q_valid,
  output prl_pkg::req_t q_req,
  input  logic          q_pop
);
  import prl_pkg::*;

  req_t       slot [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] level;
  logic       push;

  assign in_stall = (level == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (level != 2'd0);
  assign q_req    = slot[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wptr] <= in_req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      level <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (q_pop) rptr <= ~rptr;
      unique case ({push, q_pop})
        2'b10:   level <= level + 2'd1;
        2'b01:   level <= level - 2'd1;
        default: level <= level;
      endcase
    end
  end

endmodule

// ----- hdl/prl_engine.sv -----
// Back end: sequential table search, entry update and result register.
module prl_engine #(
  parameter int unsigned TABLE_ENTRIES = 256
) (
  input  logic                       clk,
  input  logic                       rst,
  input  prl_pkg::cfg_t              cfg,
  input  logic                       q_valid,
  input  prl_pkg::req_t              q_req,
  output logic                       q_pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       accept,
  output logic [1:0]                 entry_status,
  output logic [prl_pkg::CNT_W-1:0]  packet_count,
  output logic [$clog2(TABLE_ENTRIES+1)-1:0] fill_level
);
  import prl_pkg::*;

  localparam int unsigned IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(TABLE_ENTRIES+1);

  typedef enum logic [2:0] {S_IDLE, S_PRIME, S_SCAN, S_FETCH, S_UPD, S_MISS} state_t;

  state_t            state;
  req_t              cur;
  logic [ADDR_W-1:0] addr_mem [TABLE_ENTRIES];
  rec_t              data_mem [TABLE_ENTRIES];
  logic [ADDR_W-1:0] addr_rd;
  rec_t              data_rd;
  logic [IW-1:0]     scan_idx;
  logic [IW-1:0]     cmp_idx;
  logic [IW-1:0]     hit_idx;
  logic [CW-1:0]     fill;
  logic              out_free;
  logic              out_load;
  logic              expired;
  logic [CNT_W-1:0]  cnt_next;
  rec_t              upd_rec;
  rec_t              new_rec;

  assign out_free   = !out_valid || !out_stall;
  assign out_load   = ((state == S_UPD) || (state == S_MISS)) && out_free;
  assign q_pop      = (state == S_IDLE) && q_valid;
  assign fill_level = fill;

  always_comb begin
    expired = !data_rd.age[TIME_W-1] && (data_rd.age[TIME_W-2:0] > cfg.expiry);
    new_rec.count      = CNT_W'(1);
    new_rec.first_seen = cur.now;
    new_rec.age        = '0;
    if (expired) begin
      upd_rec = new_rec;
    end else begin
      upd_rec.count      = (data_rd.count == CNT_MAX) ? CNT_MAX : data_rd.count + CNT_W'(1);
      upd_rec.first_seen = data_rd.first_seen;
      upd_rec.age        = cur.now - data_rd.first_seen;
    end
    cnt_next = upd_rec.count;
  end

  always_ff @(posedge clk) begin
    addr_rd <= addr_mem[scan_idx];
    data_rd <= data_mem[hit_idx];
    if (state == S_UPD && out_free) begin
      data_mem[hit_idx] <= upd_rec;
    end
    if (state == S_MISS && out_free && fill != CW'(TABLE_ENTRIES)) begin
      addr_mem[fill[IW-1:0]] <= cur.addr;
      data_mem[fill[IW-1:0]] <= new_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      out_valid <= 1'b0;
      scan_idx  <= '0;
      cmp_idx   <= '0;
      hit_idx   <= '0;
    end else begin
      if (out_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur      <= q_req;
            scan_idx <= '0;
            state    <= (fill == '0) ? S_MISS : S_PRIME;
          end
        end
        S_PRIME: begin
          cmp_idx  <= scan_idx;
          scan_idx <= scan_idx + IW'(1);
          state    <= S_SCAN;
        end
        S_SCAN: begin
          priority if (addr_rd == cur.addr) begin
            hit_idx <= cmp_idx;
            state   <= S_FETCH;
          end else if (CW'(cmp_idx) + CW'(1) == fill) begin
            state <= S_MISS;
          end else begin
            cmp_idx  <= scan_idx;
            scan_idx <= scan_idx + IW'(1);
          end
        end
        S_FETCH: begin
          state <= S_UPD;
        end
        S_UPD: begin
          if (out_free) begin
            entry_status <= expired ? ST_RENEWED : ST_UPDATED;
            packet_count <= cnt_next;
            accept       <= !(cnt_next > {1'b0, cfg.limit});
            state        <= S_IDLE;
          end
        end
        S_MISS: begin
          if (out_free) begin
            if (fill == CW'(TABLE_ENTRIES)) begin
              entry_status <= ST_FULL;
              packet_count <= '0;
              accept       <= 1'b1;
            end else begin
              fill         <= fill + CW'(1);
              entry_status <= ST_NEW;
              packet_count <= CNT_W'(1);
              accept       <= !(CNT_W'(1) > {1'b0, cfg.limit});
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- hdl/per_source_packet_rate_limiter_core.sv -----
// Top level of the per-source packet rate limiter.
// Each request is popped from the two-deep input queue; unless the table is empty, the
// engine primes and scans the stored source addresses, then fetches and updates the
// entry on a hit, or adds an entry on a miss if there is room. No request is popped until
// the last result is loaded; the queue and result register let both sides stall independently.
// Reset: synchronous, clears the table fill count, queue and result valid; registers
// return to expiry 600 and limit 1000. Table contents need no clearing.
module per_source_packet_rate_limiter_core #(
  parameter int unsigned TABLE_ENTRIES = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [prl_pkg::ADDR_W-1:0]    source_addr,
  input  logic [prl_pkg::TIME_W-1:0]    time_now,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          accept,
  output logic [1:0]                    entry_status,
  output logic [prl_pkg::CNT_W-1:0]     packet_count,
  input  logic                          cfg_we,
  input  logic [prl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [prl_pkg::CFG_W-1:0]     cfg_data
);
  import prl_pkg::*;

  localparam int unsigned CW = $clog2(TABLE_ENTRIES+1);

  cfg_t          cfg;
  req_t          in_req;
  req_t          q_req;
  logic          q_valid;
  logic          q_pop;
  logic [CW-1:0] fill_level;

  assign in_req.addr = source_addr;
  assign in_req.now  = time_now;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.expiry <= EXPIRY_RESET;
      cfg.limit  <= LIMIT_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_EXPIRY) cfg.expiry <= cfg_data;
      if (cfg_index == REG_LIMIT)  cfg.limit  <= cfg_data;
    end
  end

  prl_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_req   (in_req),
    .q_valid  (q_valid),
    .q_req    (q_req),
    .q_pop    (q_pop)
  );

  prl_engine #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_engine (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_valid      (q_valid),
    .q_req        (q_req),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .accept       (accept),
    .entry_status (entry_status),
    .packet_count (packet_count),
    .fill_level   (fill_level)
  );

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_level <= CW'(TABLE_ENTRIES))
    else $error("table fill beyond capacity");

  a_full_untracked: assert property (@(posedge clk) disable iff (rst)
    out_valid && entry_status == ST_FULL |-> packet_count == '0 && accept)
    else $error("untracked result not clean");

  a_new_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && (entry_status == ST_NEW || entry_status == ST_RENEWED)
      |-> packet_count == CNT_W'(1))
    else $error("fresh window count not one");

  a_full_only_when_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && entry_status == ST_FULL |-> fill_level == CW'(TABLE_ENTRIES))
    else $error("untracked while table has room");

endmodule
